/* design/cbm_pkg.sv */
// Shared types, codes and constants for the cartridge bank mapper.
// No dependencies; every other design file uses this package.
`default_nettype none

package cbm_pkg;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned MAPPED_W = 21;
    localparam int unsigned TARGET_W = 2;

    localparam logic [TARGET_W-1:0] TGT_NONE = 2'd0;
    localparam logic [TARGET_W-1:0] TGT_ROM  = 2'd1;
    localparam logic [TARGET_W-1:0] TGT_RAM  = 2'd2;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Control write ranges and the RAM window, by bus_address[15:13]
    localparam logic [2:0] REGION_RAM_EN   = 3'd0;
    localparam logic [2:0] REGION_ROM_LOW  = 3'd1;
    localparam logic [2:0] REGION_UPPER    = 3'd2;
    localparam logic [2:0] REGION_MODE     = 3'd3;
    localparam logic [2:0] REGION_RAM_WIN  = 3'd5;

    localparam logic [3:0] RAM_EN_KEY    = 4'hA;
    localparam logic [4:0] ROM_LOW_RESET = 5'd1;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_access;

    typedef struct packed {
        logic [4:0] rom_low;
        logic [1:0] rom_high;
        logic [1:0] ram_sel;
        logic       ram_mode;
        logic       ram_en;
    } t_bank_state;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [MAPPED_W-1:0] mapped;
        logic                ram_on;
    } t_result;

endpackage

`default_nettype wire

/* design/cartridge_bank_mapper.sv */
// Cartridge bank mapper: one bus access word in, one mapping word out.
// Depends on cbm_pkg, cbm_regs and cbm_map.
//
// Each access word passes an input register, then the register update and the
// address mapping, then the result register. One word per cycle is sustained
// unless i_ready stalls the output; one combinational step lies between the two
// registers. Writes give target none and show the RAM enable after the write.
`default_nettype none

module cartridge_bank_mapper (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire                            i_command,
    input  wire  [cbm_pkg::ADDR_W-1:0]     i_bus_address,
    input  wire  [cbm_pkg::DATA_W-1:0]     i_write_byte,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [cbm_pkg::TARGET_W-1:0]   o_target,
    output logic [cbm_pkg::MAPPED_W-1:0]   o_mapped_address,
    output logic                           o_ram_on
);

    logic                 r_in_valid;
    cbm_pkg::t_access     r_acc;
    logic                 r_out_valid;
    cbm_pkg::t_result     r_res;
    cbm_pkg::t_bank_state w_next;
    cbm_pkg::t_result     w_res;
    logic                 w_adv;

    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc.cmd  <= i_command;
            r_acc.addr <= i_bus_address;
            r_acc.data <= i_write_byte;
        end
    end

    cbm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_acc   (r_acc),
        .o_next  (w_next)
    );

    cbm_map u_map (
        .i_acc   (r_acc),
        .i_state (w_next),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_target         = r_res.target;
    assign o_mapped_address = r_res.mapped;
    assign o_ram_on         = r_res.ram_on;

endmodule

`default_nettype wire

/* design/cbm_regs.sv */
// Banking control registers and their write decode.
// Depends on cbm_pkg.
`default_nettype none

module cbm_regs (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  cbm_pkg::t_access     i_acc,
    output cbm_pkg::t_bank_state o_next
);

    cbm_pkg::t_bank_state r_state;
    cbm_pkg::t_bank_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_acc.cmd == cbm_pkg::CMD_WRITE) begin
            unique case (i_acc.addr[15:13])
                cbm_pkg::REGION_RAM_EN: begin
                    n_state.ram_en = (i_acc.data[3:0] == cbm_pkg::RAM_EN_KEY);
                end
                cbm_pkg::REGION_ROM_LOW: begin
                    n_state.rom_low = (i_acc.data[4:0] == 5'd0) ?
                                      cbm_pkg::ROM_LOW_RESET : i_acc.data[4:0];
                end
                cbm_pkg::REGION_UPPER: begin
                    if (r_state.ram_mode) begin
                        n_state.ram_sel = i_acc.data[1:0];
                    end else begin
                        n_state.rom_high = i_acc.data[1:0];
                    end
                end
                cbm_pkg::REGION_MODE: begin
                    n_state.ram_mode = (i_acc.data != '0);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.rom_low  <= cbm_pkg::ROM_LOW_RESET;
            r_state.rom_high <= '0;
            r_state.ram_sel  <= '0;
            r_state.ram_mode <= 1'b0;
            r_state.ram_en   <= 1'b0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_next = n_state;

endmodule

`default_nettype wire

/* design/cbm_map.sv */
// Address decode and bank mapping of one bus access.
// Depends on cbm_pkg.
`default_nettype none

module cbm_map (
    input  cbm_pkg::t_access     i_acc,
    input  cbm_pkg::t_bank_state i_state,
    output cbm_pkg::t_result     o_res
);

    always_comb begin
        o_res.target = cbm_pkg::TGT_NONE;
        o_res.mapped = '0;
        o_res.ram_on = i_state.ram_en;
        if (i_acc.cmd == cbm_pkg::CMD_READ) begin
            if (i_acc.addr[15:14] == 2'b00) begin
                o_res.target = cbm_pkg::TGT_ROM;
                o_res.mapped = {5'd0, i_acc.addr};
            end else if (i_acc.addr[15:14] == 2'b01) begin
                o_res.target = cbm_pkg::TGT_ROM;
                o_res.mapped = {i_state.rom_high, i_state.rom_low, i_acc.addr[13:0]};
            end else if (i_acc.addr[15:13] == cbm_pkg::REGION_RAM_WIN) begin
                o_res.target = cbm_pkg::TGT_RAM;
                o_res.mapped = {6'd0, i_state.ram_sel, i_acc.addr[12:0]};
            end
        end
    end

endmodule

`default_nettype wire

/* design/cbm_checker.sv */
// Port-level checks of the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg and cartridge_bank_mapper.
`default_nettype none

module cbm_port_checks (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_valid,
    input wire                          i_ready,
    input wire [cbm_pkg::TARGET_W-1:0]  o_target,
    input wire [cbm_pkg::MAPPED_W-1:0]  o_mapped_address,
    input wire                          o_ram_on
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_target)
            && $stable(o_mapped_address) && $stable(o_ram_on))
        else $error("result word changed while stalled");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_target == cbm_pkg::TGT_NONE |-> o_mapped_address == '0)
        else $error("unmapped word carries an address");

    a_ram_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_target == cbm_pkg::TGT_RAM |-> o_mapped_address[20:15] == '0)
        else $error("RAM address out of range");

    a_no_bank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_target == cbm_pkg::TGT_ROM && o_mapped_address[18:14] == '0
            |-> o_mapped_address[20:19] == '0)
        else $error("switchable ROM window mapped to a zero low bank");

endmodule

bind cartridge_bank_mapper cbm_port_checks u_cbm_port_checks (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_target         (o_target),
    .o_mapped_address (o_mapped_address),
    .o_ram_on         (o_ram_on)
);

`default_nettype wire
